// File: hw/rtl/mmrc_pkg.sv
// mmrc_pkg: shared types, constants and codes for the modbus meter response checker
// no dependencies; used by every module of the block
package mmrc_pkg;

    localparam int FRAME_BYTES = 61;
    localparam int WORD_COUNT  = 13;
    localparam int COUNT_W     = 7;
    localparam int IDX_W       = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // word slots cleared by a timeout, length or crc failure
    localparam logic [WORD_COUNT-1:0] LIVE_MASK = 13'h0BD7;

    localparam logic [IDX_W-1:0] IDX_P1   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_P2   = 4'd9;
    localparam logic [IDX_W-1:0] IDX_LAST = 4'd12;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_END      = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_CRC     = 3'd3,
        ST_ADDRESS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CMP,
        S_UPD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } crc_ctl_t;

    typedef struct packed {
        logic       take;
        logic       clear;
        logic [7:0] data;
    } frame_ctl_t;

endpackage

// File: hw/rtl/mmrc_crc.sv
// mmrc_crc: bit-serial crc-16/modbus engine, one data bit per cycle
// depends on mmrc_pkg
module mmrc_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  mmrc_pkg::crc_ctl_t ctl,
    output logic [15:0]       crc,
    output logic              busy
);

    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        fb;

    always_comb
    begin
        crc_next  = crc_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fb        = crc_reg[0] ^ data_reg[0];
        if (ctl.clear)
        begin
            crc_next  = mmrc_pkg::CRC_INIT;
            busy_next = 1'b0;
        end
        else if (ctl.start)
        begin
            data_next = ctl.data;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next  = (crc_reg >> 1) ^ (fb ? mmrc_pkg::CRC_POLY : 16'h0000);
            data_next = data_reg >> 1;
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= mmrc_pkg::CRC_INIT;
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule

// File: hw/rtl/mmrc_frame.sv
// mmrc_frame: byte counter, frame header/trailer bytes and big-endian word assembly
// depends on mmrc_pkg
module mmrc_frame (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmrc_pkg::frame_ctl_t         ctl,
    input  logic [mmrc_pkg::IDX_W-1:0]   rd_idx,
    output logic [mmrc_pkg::COUNT_W-1:0] count,
    output logic [7:0]                   addr,
    output logic [7:0]                   sign1,
    output logic [7:0]                   sign2,
    output logic [15:0]                  crc_rx,
    output logic [31:0]                  rd_word
);

    logic [mmrc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]  addr_reg, sign1_reg, sign2_reg, crcl_reg, crch_reg;
    logic [7:0]  addr_next, sign1_next, sign2_next, crcl_next, crch_next;
    logic [31:0] words_reg [mmrc_pkg::WORD_COUNT];
    logic [mmrc_pkg::COUNT_W-1:0] off_a, off_b;
    logic [mmrc_pkg::IDX_W-1:0]   wr_idx;
    logic        wr_en;
    logic        room;

    always_comb
    begin
        count_next = count_reg;
        addr_next  = addr_reg;
        sign1_next = sign1_reg;
        sign2_next = sign2_reg;
        crcl_next  = crcl_reg;
        crch_next  = crch_reg;
        wr_en      = 1'b0;
        wr_idx     = '0;
        off_a      = count_reg - 7'd3;
        off_b      = count_reg - 7'd31;
        room       = (count_reg < 7'(mmrc_pkg::FRAME_BYTES));
        if (ctl.clear)
        begin
            count_next = '0;
            addr_next  = '0;
            sign1_next = '0;
            sign2_next = '0;
            crcl_next  = '0;
            crch_next  = '0;
        end
        else if (ctl.take && room)
        begin
            count_next = count_reg + 7'd1;
            if (count_reg == 7'd0)
            begin
                addr_next = ctl.data;
            end
            else if (count_reg >= 7'd3 && count_reg <= 7'd26)
            begin
                wr_en  = 1'b1;
                wr_idx = off_a[5:2];
            end
            else if (count_reg == 7'd27)
            begin
                sign1_next = ctl.data;
            end
            else if (count_reg == 7'd28)
            begin
                sign2_next = ctl.data;
            end
            else if (count_reg >= 7'd31 && count_reg <= 7'd58)
            begin
                wr_en  = 1'b1;
                wr_idx = 4'd6 + {1'b0, off_b[4:2]};
            end
            else if (count_reg == 7'(mmrc_pkg::FRAME_BYTES - 2))
            begin
                crcl_next = ctl.data;
            end
            else if (count_reg == 7'(mmrc_pkg::FRAME_BYTES - 1))
            begin
                crch_next = ctl.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
            sign1_reg <= '0;
            sign2_reg <= '0;
            crcl_reg  <= '0;
            crch_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            addr_reg  <= addr_next;
            sign1_reg <= sign1_next;
            sign2_reg <= sign2_next;
            crcl_reg  <= crcl_next;
            crch_reg  <= crch_next;
        end
    end

    // words shift in a byte at a time, most significant first
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            words_reg[wr_idx] <= {words_reg[wr_idx][23:0], ctl.data};
        end
    end

    assign count   = count_reg;
    assign addr    = addr_reg;
    assign sign1   = sign1_reg;
    assign sign2   = sign2_reg;
    assign crc_rx  = {crch_reg, crcl_reg};
    assign rd_word = words_reg[rd_idx];

endmodule

// File: hw/rtl/modbus_meter_response_checker.sv
// modbus_meter_response_checker: top level, sequencer, stored values and result register
// depends on mmrc_pkg, mmrc_crc and mmrc_frame
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  input    | in_valid / in_ready  | opcode, byte_value
//  result   | out_valid / out_ready| result_kind, status, device_address, changed,
//           |                      | word_index, word_value, negative, last
//  config   | cfg_we               | cfg_data (expected address)
//
// a byte that feeds the crc is accepted, then shifted bit by bit in the bit-serial crc
// engine, then idle again; the trailing crc pair and excess bytes are taken in idle
// good frame end: 13 word compares, an update, 14 results at one per cycle unless stalled
// a failed frame end loads its one result at the accept edge
// a new request waits until the result register is empty and the sequencer idle
// reset clears the frame, crc, stored values and the expected address
module modbus_meter_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [2:0]  status,
    output logic [7:0]  device_address,
    output logic        changed,
    output logic [3:0]  word_index,
    output logic [31:0] word_value,
    output logic        negative,
    output logic        last,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);

    mmrc_pkg::state_t   state_reg, state_next;
    mmrc_pkg::crc_ctl_t   crc_ctl;
    mmrc_pkg::frame_ctl_t frame_ctl;

    logic [7:0]  exp_addr_reg;
    logic [mmrc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic        changed_reg, changed_next;
    logic [7:0]  addr_reg;
    logic [1:0]  signs_reg;

    logic [31:0] stored_words_reg [mmrc_pkg::WORD_COUNT];
    logic [1:0]  stored_signs_reg;
    logic [7:0]  stored_addr_reg;

    // frame words are copied through a sequenced read during compare
    logic [31:0] shadow_reg [mmrc_pkg::WORD_COUNT];

    logic        out_valid_reg;
    logic        out_kind_reg, out_changed_reg, out_neg_reg, out_last_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_addr_reg;
    logic [3:0]  out_idx_reg;
    logic [31:0] out_word_reg;

    logic [15:0] crc_val;
    logic        crc_busy;
    logic [mmrc_pkg::COUNT_W-1:0] f_count;
    logic [7:0]  f_addr, f_sign1, f_sign2;
    logic [15:0] f_crc_rx;
    logic [31:0] f_word;
    logic [mmrc_pkg::IDX_W-1:0] rd_idx;

    logic        in_acc, out_free, out_load;
    logic        end_acc, byte_acc;
    logic        clear_live;
    logic        do_copy;
    mmrc_pkg::status_t frame_status;
    logic [1:0]  frame_signs;
    logic [mmrc_pkg::IDX_W-1:0] emit_w;
    logic        diff_now;

    // result being loaded
    logic        ld_kind, ld_changed, ld_neg, ld_last;
    logic [2:0]  ld_status;
    logic [7:0]  ld_addr;
    logic [3:0]  ld_idx;
    logic [31:0] ld_word;

    assign in_ready = (state_reg == mmrc_pkg::S_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign byte_acc = in_acc && (opcode == mmrc_pkg::OP_BYTE);
    assign end_acc  = in_acc && (opcode == mmrc_pkg::OP_END);
    assign out_free = !out_valid_reg || out_ready;
    assign emit_w   = idx_reg - 4'd1;

    // frame check order: timeout, length, crc, address
    always_comb
    begin
        if (f_count == '0)
        begin
            frame_status = mmrc_pkg::ST_TIMEOUT;
        end
        else if (f_count != 7'(mmrc_pkg::FRAME_BYTES))
        begin
            frame_status = mmrc_pkg::ST_LENGTH;
        end
        else if (f_crc_rx != crc_val)
        begin
            frame_status = mmrc_pkg::ST_CRC;
        end
        else if (exp_addr_reg != 8'd0 && exp_addr_reg != f_addr)
        begin
            frame_status = mmrc_pkg::ST_ADDRESS;
        end
        else
        begin
            frame_status = mmrc_pkg::ST_OK;
        end
    end

    assign frame_signs = {f_sign2 == 8'd1, f_sign1 == 8'd1};

    // crc runs over every byte but the trailing crc pair
    always_comb
    begin
        crc_ctl.clear  = end_acc;
        crc_ctl.start  = byte_acc && (f_count < 7'(mmrc_pkg::FRAME_BYTES - 2));
        crc_ctl.data   = byte_value;
        frame_ctl.take  = byte_acc;
        frame_ctl.clear = end_acc;
        frame_ctl.data  = byte_value;
    end

    assign rd_idx = (state_reg == mmrc_pkg::S_EMIT) ? emit_w : idx_reg;

    mmrc_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    mmrc_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (frame_ctl),
        .rd_idx  (rd_idx),
        .count   (f_count),
        .addr    (f_addr),
        .sign1   (f_sign1),
        .sign2   (f_sign2),
        .crc_rx  (f_crc_rx),
        .rd_word (f_word)
    );

    // one stored word compared per cycle; power signs count only on a nonzero word
    always_comb
    begin
        diff_now = (f_word != stored_words_reg[idx_reg]);
        if (idx_reg == mmrc_pkg::IDX_P1 && f_word != 32'd0
            && (signs_reg[0] != stored_signs_reg[0]))
        begin
            diff_now = 1'b1;
        end
        if (idx_reg == mmrc_pkg::IDX_P2 && f_word != 32'd0
            && (signs_reg[1] != stored_signs_reg[1]))
        begin
            diff_now = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmrc_pkg::S_IDLE:
            begin
                if (crc_ctl.start)
                begin
                    state_next = mmrc_pkg::S_CRC;
                end
                else if (end_acc && frame_status == mmrc_pkg::ST_OK)
                begin
                    state_next = mmrc_pkg::S_CMP;
                end
            end
            mmrc_pkg::S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = mmrc_pkg::S_IDLE;
                end
            end
            mmrc_pkg::S_CMP:
            begin
                if (idx_reg == mmrc_pkg::IDX_LAST)
                begin
                    state_next = mmrc_pkg::S_UPD;
                end
            end
            mmrc_pkg::S_UPD:
            begin
                state_next = mmrc_pkg::S_EMIT;
            end
            mmrc_pkg::S_EMIT:
            begin
                if (out_free && idx_reg == mmrc_pkg::IDX_LAST + 4'd1)
                begin
                    state_next = mmrc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mmrc_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        idx_next     = idx_reg;
        changed_next = changed_reg;
        out_load     = 1'b0;
        clear_live   = 1'b0;
        do_copy      = 1'b0;
        ld_kind      = mmrc_pkg::KIND_STATUS;
        ld_status    = mmrc_pkg::ST_OK;
        ld_addr      = addr_reg;
        ld_changed   = changed_reg;
        ld_idx       = '0;
        ld_word      = '0;
        ld_neg       = 1'b0;
        ld_last      = 1'b0;
        unique case (state_reg)
            mmrc_pkg::S_IDLE:
            begin
                if (end_acc)
                begin
                    idx_next     = '0;
                    changed_next = (f_addr != stored_addr_reg);
                    if (frame_status != mmrc_pkg::ST_OK)
                    begin
                        out_load   = 1'b1;
                        ld_status  = frame_status;
                        ld_addr    = (f_count == '0) ? 8'd0 : f_addr;
                        ld_changed = 1'b0;
                        ld_last    = 1'b1;
                        clear_live = (frame_status != mmrc_pkg::ST_ADDRESS);
                    end
                end
            end
            mmrc_pkg::S_CRC:
            begin
                idx_next = idx_reg;
            end
            mmrc_pkg::S_CMP:
            begin
                changed_next = changed_reg | diff_now;
                idx_next     = (idx_reg == mmrc_pkg::IDX_LAST) ? 4'd0 : idx_reg + 4'd1;
            end
            mmrc_pkg::S_UPD:
            begin
                do_copy = changed_reg;
            end
            mmrc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg != 4'd0)
                    begin
                        ld_kind = mmrc_pkg::KIND_WORD;
                        ld_idx  = emit_w;
                        ld_word = f_word;
                        ld_neg  = (emit_w == mmrc_pkg::IDX_P1 && signs_reg[0])
                                  || (emit_w == mmrc_pkg::IDX_P2 && signs_reg[1]);
                        ld_last = (emit_w == mmrc_pkg::IDX_LAST);
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mmrc_pkg::S_IDLE;
            exp_addr_reg     <= '0;
            idx_reg          <= '0;
            changed_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            stored_signs_reg <= '0;
            stored_addr_reg  <= '0;
            for (int i = 0; i < mmrc_pkg::WORD_COUNT; i++)
            begin
                stored_words_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            changed_reg <= changed_next;
            if (cfg_we)
            begin
                exp_addr_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // timeout, length or crc failures drop the live readings, energy totals are kept
            if (clear_live)
            begin
                stored_signs_reg <= '0;
                for (int i = 0; i < mmrc_pkg::WORD_COUNT; i++)
                begin
                    if (mmrc_pkg::LIVE_MASK[i])
                    begin
                        stored_words_reg[i] <= '0;
                    end
                end
            end
            else if (do_copy)
            begin
                stored_signs_reg <= signs_reg;
                stored_addr_reg  <= addr_reg;
                for (int i = 0; i < mmrc_pkg::WORD_COUNT; i++)
                begin
                    stored_words_reg[i] <= shadow_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mmrc_pkg::S_CMP)
        begin
            shadow_reg[idx_reg] <= f_word;
        end
    end

    // frame address and sign flags held for the compare and the results
    always_ff @(posedge clk)
    begin
        if (end_acc)
        begin
            addr_reg  <= f_addr;
            signs_reg <= frame_signs;
        end
        if (out_load)
        begin
            out_kind_reg    <= ld_kind;
            out_status_reg  <= ld_status;
            out_addr_reg    <= ld_addr;
            out_changed_reg <= ld_changed;
            out_idx_reg     <= ld_idx;
            out_word_reg    <= ld_word;
            out_neg_reg     <= ld_neg;
            out_last_reg    <= ld_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign status         = out_status_reg;
    assign device_address = out_addr_reg;
    assign changed        = out_changed_reg;
    assign word_index     = out_idx_reg;
    assign word_value     = out_word_reg;
    assign negative       = out_neg_reg;
    assign last           = out_last_reg;

endmodule
